@@ hw/rtl/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// sse_pkg
// Shared constants, types and the 3x3x3 extremum classifier.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS     = COL_BITS + 1;
   localparam int ROW_BITS       = 12;
   localparam int SAMPLE_BITS    = 16;
   localparam int TRIPLE_BITS    = 3 * SAMPLE_BITS;
   localparam int LINE_BITS      = 2 * TRIPLE_BITS;
   localparam int QUEUE_DEPTH    = 8;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;
   localparam int RSP_DATA_BITS  = 24;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(640);
   localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(480);

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef logic [1:0] class_type;
   localparam class_type CLASS_NONE = 2'd0;
   localparam class_type CLASS_MIN  = 2'd1;
   localparam class_type CLASS_MAX  = 2'd2;

   // [k] = lower, centre, upper scale
   typedef logic [2:0][SAMPLE_BITS-1:0] triple_type;
   // [col][row], col 0..2 = c-2..c, row 0..2 = r-2..r
   typedef triple_type [2:0][2:0] grid_type;

   typedef struct packed {
      class_type [3:0]     cls;
      logic [3:0]          mask;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   function automatic class_type classify(grid_type g, int crow, int ccol,
                                          logic [2:0] rv, logic [2:0] cv);
      logic signed [SAMPLE_BITS-1:0] centre;
      logic signed [SAMPLE_BITS-1:0] v;
      logic is_min;
      logic is_max;
      centre = g[ccol][crow][1];
      is_min = 1'b1;
      is_max = 1'b1;
      for (int cc = 0; cc < 3; cc++) begin
         for (int rr = 0; rr < 3; rr++) begin
            for (int k = 0; k < 3; k++) begin
               if (cv[cc] && rv[rr] && cc >= ccol - 1 && cc <= ccol + 1 &&
                   rr >= crow - 1 && rr <= crow + 1) begin
                  v = g[cc][rr][k];
                  if (centre > v) is_min = 1'b0;
                  if (centre < v) is_max = 1'b0;
               end
            end
         end
      end
      if (is_max) return CLASS_MAX;
      if (is_min) return CLASS_MIN;
      return CLASS_NONE;
   endfunction

endpackage

@@ hw/rtl/sse_ram.sv @@
// ----------------------------------------------------------------------------
// sse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sse_front.sv @@
// ----------------------------------------------------------------------------
// sse_front
// Takes pixels, keeps line store and window, classifies, pushes result sets.
// ----------------------------------------------------------------------------
module sse_front
   import sse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TRIPLE_BITS-1:0]    req_tdata,
   input  logic [QUEUE_CNT_BITS-1:0] queue_count,
   output push_type                  push
);

   logic [WIDTH_BITS-1:0] width_ff;
   logic [ROW_BITS-1:0]   height_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [WIDTH_BITS-1:0] w_eff;
   logic [ROW_BITS-1:0]   h_eff;
   logic                  last_col;
   logic                  last_row;
   logic                  accept;
   logic [QUEUE_CNT_BITS:0] occupancy;

   logic                  s1_valid_ff;
   triple_type            s1_cur_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic                  s1_last_col_ff;
   logic                  s1_last_row_ff;
   logic                  fwd_ff;
   logic [LINE_BITS-1:0]  fwd_data_ff;
   logic [LINE_BITS-1:0]  ram_rdata;
   logic [LINE_BITS-1:0]  line;
   logic [LINE_BITS-1:0]  wr_data;
   triple_type [2:0]      col2;
   triple_type [1:0][2:0] win_ff;

   logic                  s2_valid_ff;
   grid_type              s2_grid_ff;
   logic [ROW_BITS-1:0]   s2_row_ff;
   logic [COL_BITS-1:0]   s2_col_ff;
   logic                  s2_last_col_ff;
   logic                  s2_last_row_ff;
   logic [2:0]            rv_a;
   logic [2:0]            rv_b;
   logic [2:0]            cv;

   // effective frame size
   always_comb begin
      if (width_ff == '0) w_eff = WIDTH_BITS'(1);
      else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) w_eff = WIDTH_BITS'(MAX_WIDTH);
      else w_eff = width_ff;
      h_eff = (height_ff == '0) ? ROW_BITS'(1) : height_ff;
   end

   assign last_col = {1'b0, col_ff} >= (w_eff - WIDTH_BITS'(1));
   assign last_row = row_ff >= (h_eff - ROW_BITS'(1));

   // credit check: queue plus everything still in the pipe
   assign occupancy = (QUEUE_CNT_BITS+1)'(queue_count)
                    + (QUEUE_CNT_BITS+1)'(s1_valid_ff)
                    + (QUEUE_CNT_BITS+1)'(s2_valid_ff);
   assign req_tready = occupancy < (QUEUE_CNT_BITS+1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wr_data[WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wr_data[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_ff <= col_ff + COL_BITS'(1);
         end
      end
   end

   // line store: [47:0] row r-2, [95:48] row r-1
   sse_ram #(.WIDTH(LINE_BITS), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   assign line    = fwd_ff ? fwd_data_ff : ram_rdata;
   assign col2    = {s1_cur_ff, line[LINE_BITS-1:TRIPLE_BITS], line[TRIPLE_BITS-1:0]};
   assign wr_data = {s1_cur_ff, line[LINE_BITS-1:TRIPLE_BITS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= col2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff      <= req_tdata;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         // read collides with the write of the pixel ahead
         fwd_ff         <= s1_valid_ff && (s1_col_ff == col_ff);
         fwd_data_ff    <= wr_data;
      end
      if (s1_valid_ff) begin
         s2_grid_ff     <= {col2, win_ff[1], win_ff[0]};
         s2_row_ff      <= s1_row_ff;
         s2_col_ff      <= s1_col_ff;
         s2_last_col_ff <= s1_last_col_ff;
         s2_last_row_ff <= s1_last_row_ff;
      end
   end

   // stage 2: the four candidate results
   assign rv_a = {1'b1, 1'b1, s2_row_ff >= ROW_BITS'(2)};
   assign rv_b = {1'b1, s2_row_ff != '0, 1'b0};
   assign cv   = {1'b1, s2_col_ff != '0, s2_col_ff >= COL_BITS'(2)};

   always_comb begin
      push.entry.cls[0] = classify(s2_grid_ff, 1, 1, rv_a, cv);
      push.entry.cls[1] = classify(s2_grid_ff, 1, 2, rv_a, cv);
      push.entry.cls[2] = classify(s2_grid_ff, 2, 1, rv_b, cv);
      push.entry.cls[3] = classify(s2_grid_ff, 2, 2, rv_b, cv);
      push.entry.mask[0] = (s2_row_ff != '0) && (s2_col_ff != '0);
      push.entry.mask[1] = (s2_row_ff != '0) && s2_last_col_ff;
      push.entry.mask[2] = s2_last_row_ff && (s2_col_ff != '0);
      push.entry.mask[3] = s2_last_row_ff && s2_last_col_ff;
      push.entry.row     = s2_row_ff;
      push.entry.col     = s2_col_ff;
      push.valid         = s2_valid_ff && (push.entry.mask != '0);
   end

endmodule

@@ hw/rtl/sse_queue.sv @@
// ----------------------------------------------------------------------------
// sse_queue
// Small FIFO of result sets between front and back.
// ----------------------------------------------------------------------------
module sse_queue
   import sse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  push_type                  push,
   input  logic                      pop,
   output entry_type                 head,
   output logic [QUEUE_CNT_BITS-1:0] count
);

   entry_type                 entries [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push.valid) entries[wr_ptr_ff] <= push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         count_ff <= count_ff + QUEUE_CNT_BITS'(push.valid) - QUEUE_CNT_BITS'(pop);
      end
   end

   assign head  = entries[rd_ptr_ff];
   assign count = count_ff;

endmodule

@@ hw/rtl/sse_back.sv @@
// ----------------------------------------------------------------------------
// sse_back
// Unpacks each result set into single results on the output register.
// ----------------------------------------------------------------------------
module sse_back
   import sse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  entry_type                 head,
   input  logic [QUEUE_CNT_BITS-1:0] count,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                      rsp_tlast
);

   logic [3:0]          done_ff;
   logic [3:0]          pending;
   logic [3:0]          sel_oh;
   logic [1:0]          sel;
   logic                last;
   logic                load;
   logic                fire;
   logic                rsp_valid_ff;
   logic                rsp_last_ff;
   class_type           rsp_class_ff;
   logic [ROW_BITS-1:0] rsp_row_ff;
   logic [COL_BITS-1:0] rsp_col_ff;

   assign pending = head.mask & ~done_ff;

   always_comb begin
      sel = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (pending[i]) sel = 2'(i);
      end
      sel_oh = 4'b0001 << sel;
   end

   assign last = (pending & ~sel_oh) == '0;
   assign load = !rsp_valid_ff || rsp_tready;
   assign fire = (count != '0) && load;
   assign pop  = fire && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
         done_ff      <= last ? '0 : (done_ff | sel_oh);
      end else if (load) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_class_ff <= head.cls[sel];
         rsp_row_ff   <= sel[1] ? head.row : head.row - ROW_BITS'(1);
         rsp_col_ff   <= sel[0] ? head.col : head.col - COL_BITS'(1);
         rsp_last_ff  <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_row_ff, rsp_class_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/scale_space_extremum_detector.sv @@
// Path: results pass the stage 1 and 2 registers, the queue and the output register.
// Throughput: one pixel per cycle while the queue has credit; results leave one per
// cycle while rsp_tready is high, so row ends (up to four results) and the last row
// (two per pixel) hold the input back once the eight-entry queue of result sets fills.
// Reset (synchronous): counters, window and queue clear, sizes return to 640x480;
// the line store is not cleared, as each row reads only lines written earlier in the frame.
// ----------------------------------------------------------------------------
// scale_space_extremum_detector
// 3x3x3 DoG extremum classifier: front (line store, window, 4 classifiers),
// queue of result sets, back (one result transaction per cycle while rsp_tready is high).
// ----------------------------------------------------------------------------
module scale_space_extremum_detector
   import sse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration writes
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   // pixel stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TRIPLE_BITS-1:0]    req_tdata,  // lower_dog, center_dog, upper_dog
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,  // point_class, pixel_row, pixel_column
   output logic                      rsp_tlast   // last_in_run
);

   push_type                  push;
   entry_type                 head;
   logic [QUEUE_CNT_BITS-1:0] count;
   logic                      pop;

   // front: takes a pixel whenever queue credit covers everything in flight
   sse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_count (count),
      .push        (push)
   );

   // one entry per pixel that yields results
   sse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (count)
   );

   sse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .count      (count),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
